@@ hdl/echo_comb_delay_top_macros.svh @@
// Assertion macros for the echo comb delay block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ECHO_COMB_DELAY_TOP_MACROS_SVH
`define ECHO_COMB_DELAY_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define ECD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked implication, disabled while reset is high.
`define ECD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Checked next-cycle implication, disabled while reset is high.
`define ECD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ECD_ASSERT(label, clk, rst, prop, msg)
`define ECD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ECD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/ecd_pkg.sv @@
// Shared types, constants and helper functions for the echo comb delay block.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package ecd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_DELAY   = 65536;
   localparam int ADDR_BITS   = $clog2(MAX_DELAY);
   localparam int LEN_BITS    = $clog2(MAX_DELAY) + 1;
   localparam int ATT_BITS    = 16;
   localparam int ATT_FRAC    = 15;
   localparam int MODE_BITS   = 2;
   localparam int CHAN_BITS   = 2;
   localparam int SAT_IN_BITS = SAMPLE_BITS + 2;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register indexes
   localparam logic [1:0] REG_ECHO_MODE     = 2'd0;
   localparam logic [1:0] REG_DELAY_LENGTH  = 2'd1;
   localparam logic [1:0] REG_ATTENUATION   = 2'd2;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

   // echo modes
   localparam logic [MODE_BITS-1:0] MODE_PASS     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DELAY    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FEEDBACK = 2'd2;

   localparam logic [CHAN_BITS-1:0] CHAN_NONE = 2'd0;
   localparam logic [CHAN_BITS-1:0] CHAN_ONE  = 2'd1;

   localparam logic [MODE_BITS-1:0] RST_ECHO_MODE     = MODE_DELAY;
   localparam logic [LEN_BITS-1:0]  RST_DELAY_LENGTH  = LEN_BITS'(24000);
   localparam logic [ATT_BITS-1:0]  RST_ATTENUATION   = ATT_BITS'(16384);
   localparam logic [CHAN_BITS-1:0] RST_CHANNEL_COUNT = 2'd2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] echo_mode;
      logic [LEN_BITS-1:0]  delay_length;
      logic [ATT_BITS-1:0]  attenuation;
      logic [CHAN_BITS-1:0] channel_count;
   } cfg_type;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      sample_type data;
   } line_wr_type;

   // clamp a wider signed value into the sample range
   function automatic sample_type sat_sample(input logic signed [SAT_IN_BITS-1:0] x);
      logic signed [SAT_IN_BITS-1:0] hi;
      logic signed [SAT_IN_BITS-1:0] lo;
      hi = SAT_IN_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
      lo = -hi - SAT_IN_BITS'(1);
      if (x > hi) begin
         return sample_type'(hi);
      end else if (x < lo) begin
         return sample_type'(lo);
      end
      return x[SAMPLE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/ecd_req_if.sv @@
// Input stream channel: one stereo frame per transaction.
// Depends on ecd_pkg for the sample width.
`default_nettype none

interface ecd_req_if;
   import ecd_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_ch0;
   sample_type sample_ch1;
   modport source (output valid, output sample_ch0, output sample_ch1, input ready);
   modport sink (input valid, input sample_ch0, input sample_ch1, output ready);
endinterface

`default_nettype wire

@@ hdl/ecd_rsp_if.sv @@
// Result stream channel: one mono sample per transaction.
// Depends on ecd_pkg for the sample width.
`default_nettype none

interface ecd_rsp_if;
   import ecd_pkg::*;
   logic       valid;
   logic       ready;
   sample_type out_sample;
   modport source (output valid, output out_sample, input ready);
   modport sink (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

@@ hdl/echo_comb_delay_top.sv @@
// Echo comb delay top: an accepted frame passes the s1 and output registers
// before its result is valid; one frame accepted per cycle unless stalled by
// a low rsp_bus.ready or the line clear. Reset is synchronous; afterwards all
// 65536 line entries are cleared, while req_bus.ready stays low (CSR writes go on).
// Depends on ecd_pkg, ecd_req_if, ecd_rsp_if, ecd_csr, ecd_echo_line, macros.
`default_nettype none
`include "echo_comb_delay_top_macros.svh"

module echo_comb_delay_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   ecd_req_if.sink                                   req_bus,
   ecd_rsp_if.source                                 rsp_bus,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [ecd_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [ecd_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output      logic [ecd_pkg::CSR_DATA_BITS-1:0]    prdata,
   output      logic                                 pready
);
   import ecd_pkg::*;

   cfg_type     cfg;
   logic        line_busy;
   sample_type  line_rd_data;
   line_wr_type line_wr;

   logic                         req_accept;
   logic [LEN_BITS-1:0]          len_eff;
   addr_type                     cur_pos;
   logic [LEN_BITS-1:0]          pos_inc;
   addr_type                     ring_pos_ff;
   addr_type                     ring_pos_in;
   logic signed [SAMPLE_BITS:0]  frame_sum;
   sample_type                   mono;

   logic       s1_valid_ff;
   sample_type s1_mono_ff;
   addr_type   s1_addr_ff;
   logic       s1_fire;

   logic signed [SAMPLE_BITS:0]          wet_sum;
   sample_type                           wet;
   logic signed [SAMPLE_BITS+ATT_BITS:0] fb_prod;
   sample_type                           fb_val;
   sample_type                           y_val;

   logic       out_valid_ff;
   logic       out_valid_in;
   sample_type out_sample_ff;

   ecd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ecd_echo_line u_line (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (cur_pos),
      .wr      (line_wr),
      .rd_data (line_rd_data),
      .busy    (line_busy)
   );

   // handshake
   assign s1_fire       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !line_busy && (!s1_valid_ff || s1_fire);
   assign req_accept    = req_bus.valid && req_bus.ready;

   // ring position, with out-of-range lengths clamped
   always_comb begin
      if (cfg.delay_length == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (cfg.delay_length > LEN_BITS'(MAX_DELAY)) begin
         len_eff = LEN_BITS'(MAX_DELAY);
      end else begin
         len_eff = cfg.delay_length;
      end
      cur_pos     = ({1'b0, ring_pos_ff} >= len_eff) ? '0 : ring_pos_ff;
      pos_inc     = {1'b0, cur_pos} + LEN_BITS'(1);
      ring_pos_in = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_BITS-1:0];
   end

   // downmix; halving floors, so a plain arithmetic shift
   always_comb begin
      case (cfg.channel_count)
         CHAN_NONE: frame_sum = '0;
         CHAN_ONE:  frame_sum = (SAMPLE_BITS+1)'(req_bus.sample_ch0);
         default:   frame_sum = (SAMPLE_BITS+1)'(req_bus.sample_ch0)
                              + (SAMPLE_BITS+1)'(req_bus.sample_ch1);
      endcase
      mono = frame_sum[SAMPLE_BITS:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_pos_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            ring_pos_ff <= ring_pos_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mono_ff <= mono;
         s1_addr_ff <= cur_pos;
      end
   end

   // echo add and feedback scaling
   always_comb begin
      wet_sum = (SAMPLE_BITS+1)'(s1_mono_ff) + (SAMPLE_BITS+1)'(line_rd_data);
      wet     = sat_sample(SAT_IN_BITS'(wet_sum));
      fb_prod = wet * $signed({1'b0, cfg.attenuation});
      fb_val  = sat_sample(fb_prod[SAMPLE_BITS+ATT_BITS:ATT_FRAC]);
      line_wr.addr = s1_addr_ff;
      case (cfg.echo_mode)
         MODE_DELAY: begin
            y_val        = wet;
            line_wr.en   = s1_fire;
            line_wr.data = s1_mono_ff;
         end
         MODE_FEEDBACK: begin
            y_val        = wet;
            line_wr.en   = s1_fire;
            line_wr.data = fb_val;
         end
         default: begin
            y_val        = s1_mono_ff;
            line_wr.en   = 1'b0;
            line_wr.data = s1_mono_ff;
         end
      endcase
   end

   // output register
   always_comb begin
      if (s1_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_sample_ff <= y_val;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_sample = out_sample_ff;

   `ECD_ASSERT_NEXT(a_pos_in_range, clock, reset, req_accept, {1'b0, ring_pos_ff} < $past(len_eff), "ring position out of range")
   `ECD_ASSERT_IMP(a_wr_needs_item, clock, reset, line_wr.en, s1_valid_ff && !line_busy, "line write without item")
   `ECD_ASSERT_NEXT(a_pass_dry, clock, reset, s1_fire && (cfg.echo_mode != MODE_DELAY) && (cfg.echo_mode != MODE_FEEDBACK), out_sample_ff == $past(s1_mono_ff), "passthrough not dry")

endmodule

`default_nettype wire

@@ hdl/ecd_csr.sv @@
// APB-style configuration registers of the echo comb delay block.
// Depends on ecd_pkg.
`default_nettype none

module ecd_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [ecd_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [ecd_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output      logic [ecd_pkg::CSR_DATA_BITS-1:0]    prdata,
   output      logic                                 pready,
   output      ecd_pkg::cfg_type                     cfg
);
   import ecd_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_mode     <= RST_ECHO_MODE;
         cfg_ff.delay_length  <= RST_DELAY_LENGTH;
         cfg_ff.attenuation   <= RST_ATTENUATION;
         cfg_ff.channel_count <= RST_CHANNEL_COUNT;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_ECHO_MODE:     cfg_ff.echo_mode     <= pwdata[MODE_BITS-1:0];
            REG_DELAY_LENGTH:  cfg_ff.delay_length  <= pwdata[LEN_BITS-1:0];
            REG_ATTENUATION:   cfg_ff.attenuation   <= pwdata[ATT_BITS-1:0];
            REG_CHANNEL_COUNT: cfg_ff.channel_count <= pwdata[CHAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_ECHO_MODE:     prdata = CSR_DATA_BITS'(cfg_ff.echo_mode);
         REG_DELAY_LENGTH:  prdata = CSR_DATA_BITS'(cfg_ff.delay_length);
         REG_ATTENUATION:   prdata = CSR_DATA_BITS'(cfg_ff.attenuation);
         REG_CHANNEL_COUNT: prdata = CSR_DATA_BITS'(cfg_ff.channel_count);
         default:           prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/ecd_echo_line.sv @@
// Echo delay line memory with registered read, write-to-read bypass and
// a clearing pass after reset. Depends on ecd_pkg and the assertion macros.
`default_nettype none
`include "echo_comb_delay_top_macros.svh"

module ecd_echo_line (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire ecd_pkg::addr_type     rd_addr,
   input  wire ecd_pkg::line_wr_type  wr,
   output      ecd_pkg::sample_type   rd_data,
   output      logic                  busy
);
   import ecd_pkg::*;

   sample_type echo_mem [MAX_DELAY];
   sample_type rd_data_ff;
   logic       clr_active_ff;
   addr_type   clr_addr_ff;
   logic       mem_we;
   addr_type   mem_waddr;
   sample_type mem_wdata;

   assign busy    = clr_active_ff;
   assign rd_data = rd_data_ff;

   always_comb begin
      if (clr_active_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wr.en;
         mem_waddr = wr.addr;
         mem_wdata = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         echo_mem[mem_waddr] <= mem_wdata;
      end
   end

   // a write in the same cycle as a read of that entry is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= echo_mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
         if (clr_addr_ff == '1) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   `ECD_ASSERT(a_no_wr_in_clear, clock, reset, !(clr_active_ff && wr.en), "write during clear")
   `ECD_ASSERT_IMP(a_no_rd_in_clear, clock, reset, rd_en, !clr_active_ff, "read during clear")

endmodule

`default_nettype wire
